@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, constants and helpers for the text console character writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default geometry
  localparam int unsigned CONSOLES_DEF  = 7;
  localparam int unsigned ROWS_DEF      = 64;
  localparam int unsigned COLUMNS_DEF   = 80;
  localparam int unsigned TAB_WIDTH_DEF = 8;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // apb port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // character codes
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // blank cell: space, colour 7 on 0
  localparam logic [3:0]  BLANK_FG   = 4'd7;
  localparam logic [3:0]  BLANK_BG   = 4'd0;
  localparam logic [15:0] BLANK_CELL = {BLANK_BG, BLANK_FG, CHAR_SPACE};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic {
    REG_TEXT_FG = 1'b0,
    REG_TEXT_BG = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_INVALID,
    CMD_READ,
    CMD_READ_OOR,
    CMD_LF,
    CMD_CR,
    CMD_TAB,
    CMD_BS,
    CMD_PRINT
  } cmd_kind_e;

  // one classified request
  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] con;
    logic [7:0] char_code;
    logic [5:0] row;
    logic [6:0] col;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ROW,
    ST_ADDR,
    ST_SCROLL,
    ST_PUT,
    ST_TAB,
    ST_RD,
    ST_RDWAIT,
    ST_RESP
  } back_state_e;

  function automatic logic [15:0] make_cell(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

@@ src/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// accepts requests and classifies them into commands for the back end
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int unsigned CONSOLES = CONSOLES_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned COLUMNS  = COLUMNS_DEF
) (
  input  logic       en_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [2:0] console_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] row_i,
  input  logic [6:0] col_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic con_ok, pos_ok;

  assign con_ok     = 32'(console_i) < CONSOLES;
  assign pos_ok     = (32'(row_i) < ROWS) && (32'(col_i) < COLUMNS);
  assign in_ready_o = en_i && !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.con       = con_ok ? console_i : '0;
    cmd_o.char_code = char_code_i;
    cmd_o.row       = row_i;
    cmd_o.col       = col_i;
    if (!con_ok) begin
      cmd_o.kind = CMD_INVALID;
    end else if (op_e'(opcode_i) == OP_READ) begin
      cmd_o.kind = pos_ok ? CMD_READ : CMD_READ_OOR;
    end else begin
      unique case (char_code_i)
        CHAR_LF:  cmd_o.kind = CMD_LF;
        CHAR_CR:  cmd_o.kind = CMD_CR;
        CHAR_TAB: cmd_o.kind = CMD_TAB;
        CHAR_BS:  cmd_o.kind = CMD_BS;
        default:  cmd_o.kind = CMD_PRINT;
      endcase
    end
  end

endmodule

@@ src/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

@@ src/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// sequencer that carries out commands on the cell store and cursor state
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned CONSOLES  = CONSOLES_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] fg_i,
  input  logic [3:0] bg_i,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       clear_done_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_accepted_o,
  output logic [7:0] out_cell_char_o,
  output logic [3:0] out_cell_fg_o,
  output logic [3:0] out_cell_bg_o,
  output logic [5:0] out_cursor_row_o,
  output logic [6:0] out_cursor_col_o
);

  localparam int unsigned DEPTH  = CONSOLES * ROWS * COLUMNS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CON_W  = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int unsigned CROW_W = $clog2(ROWS);
  localparam int unsigned PS_W   = CROW_W + 1;
  localparam int unsigned CCOL_W = $clog2(COLUMNS + 1);
  localparam int unsigned SW_W   = $clog2(COLUMNS);
  localparam int unsigned PH_W   = $clog2(TAB_WIDTH);
  localparam int unsigned RIDX_W = $clog2(CONSOLES * ROWS);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [CON_W-1:0]  con_q, con_d;
  logic [CROW_W-1:0] cr_q, cr_d, base_q, base_d;
  logic [CCOL_W-1:0] cc_q, cc_d;
  logic [PH_W-1:0]   ph_q, ph_d;
  logic              scroll_q, scroll_d;
  logic [SW_W-1:0]   sw_q, sw_d;
  logic [RIDX_W-1:0] rowidx_q, rowidx_d;
  logic [AW-1:0]     rowbase_q, rowbase_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [15:0]       rcell_q, rcell_d;

  logic [CROW_W-1:0] cur_row_q [CONSOLES];
  logic [CCOL_W-1:0] cur_col_q [CONSOLES];
  logic [PH_W-1:0]   cur_ph_q  [CONSOLES];
  logic [CROW_W-1:0] ring_q    [CONSOLES];

  logic        out_valid_q;
  logic        out_acc_q;
  logic [15:0] out_cell_q;
  logic [5:0]  out_row_q;
  logic [6:0]  out_col_q;
  logic        load_out;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic [CON_W-1:0]  con_in;
  logic              lf_scroll;
  logic [CROW_W-1:0] base_inc, lrow;
  logic [PS_W-1:0]   psum;
  logic [CROW_W-1:0] prow;
  logic [PH_W-1:0]   ph_inc, ph_dec;
  logic [SW_W-1:0]   col_sel;
  logic              is_read;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign con_in    = CON_W'(cmd_i.con);
  assign is_read   = (cmd_q.kind == CMD_READ);
  assign lf_scroll = (cr_q == CROW_W'(ROWS - 1));
  assign base_inc  = (base_q == CROW_W'(ROWS - 1)) ? '0 : base_q + 1'b1;
  assign ph_inc    = (ph_q == PH_W'(TAB_WIDTH - 1)) ? '0 : ph_q + 1'b1;
  assign ph_dec    = (ph_q == '0) ? PH_W'(TAB_WIDTH - 1) : ph_q - 1'b1;
  assign lrow      = is_read ? CROW_W'(cmd_q.row) : cr_q;
  assign psum      = PS_W'(base_q) + PS_W'(lrow);
  assign prow      = (psum >= PS_W'(ROWS)) ? CROW_W'(psum - PS_W'(ROWS)) : CROW_W'(psum);

  // column for the current ram access
  always_comb begin
    if (state_q == ST_SCROLL) begin
      col_sel = sw_q;
    end else if (is_read) begin
      col_sel = SW_W'(cmd_q.col);
    end else begin
      col_sel = SW_W'(cc_q);
    end
  end

  assign clear_done_o = (state_q != ST_CLEAR);
  assign load_out     = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    con_d     = con_q;
    cr_d      = cr_q;
    cc_d      = cc_q;
    ph_d      = ph_q;
    base_d    = base_q;
    scroll_d  = scroll_q;
    sw_d      = sw_q;
    rowidx_d  = rowidx_q;
    rowbase_d = rowbase_q;
    clr_d     = clr_q;
    rcell_d   = rcell_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rowbase_q + AW'(col_sel);
    ram_wdata = BLANK_CELL;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          con_d    = con_in;
          cr_d     = cur_row_q[con_in];
          cc_d     = cur_col_q[con_in];
          ph_d     = cur_ph_q[con_in];
          base_d   = ring_q[con_in];
          scroll_d = 1'b0;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (cmd_q.kind) inside
          CMD_INVALID, CMD_READ_OOR: begin
            state_d = ST_RESP;
          end
          CMD_CR: begin
            cc_d    = '0;
            ph_d    = '0;
            state_d = ST_RESP;
          end
          CMD_LF: begin
            cc_d = '0;
            ph_d = '0;
            if (lf_scroll) begin
              base_d   = base_inc;
              scroll_d = 1'b1;
              state_d  = ST_ROW;
            end else begin
              cr_d    = cr_q + 1'b1;
              state_d = ST_RESP;
            end
          end
          CMD_PRINT: begin
            // full row wraps first
            if (cc_q >= CCOL_W'(COLUMNS)) begin
              cc_d = '0;
              ph_d = '0;
              if (lf_scroll) begin
                base_d   = base_inc;
                scroll_d = 1'b1;
              end else begin
                cr_d = cr_q + 1'b1;
              end
            end
            state_d = ST_ROW;
          end
          CMD_TAB: begin
            state_d = (cc_q >= CCOL_W'(COLUMNS)) ? ST_RESP : ST_ROW;
          end
          CMD_BS: begin
            if (cc_q != '0) begin
              cc_d = cc_q - 1'b1;
              ph_d = ph_dec;
            end
            state_d = ST_ROW;
          end
          default: begin
            state_d = ST_ROW;
          end
        endcase
      end
      ST_ROW: begin
        rowidx_d = RIDX_W'(con_q) * RIDX_W'(ROWS) + RIDX_W'(prow);
        sw_d     = '0;
        state_d  = ST_ADDR;
      end
      ST_ADDR: begin
        rowbase_d = AW'(rowidx_q) * AW'(COLUMNS);
        if (scroll_q) begin
          state_d = ST_SCROLL;
        end else begin
          unique case (cmd_q.kind) inside
            CMD_PRINT:       state_d = ST_PUT;
            CMD_TAB:         state_d = ST_TAB;
            CMD_READ, CMD_BS: state_d = ST_RD;
            default:         state_d = ST_RESP;
          endcase
        end
      end
      ST_SCROLL: begin
        ram_we = 1'b1;
        sw_d   = sw_q + 1'b1;
        if (sw_q == SW_W'(COLUMNS - 1)) begin
          scroll_d = 1'b0;
          state_d  = (cmd_q.kind == CMD_PRINT) ? ST_PUT : ST_RESP;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = make_cell(cmd_q.char_code, fg_i, bg_i);
        cc_d      = cc_q + 1'b1;
        ph_d      = ph_inc;
        state_d   = ST_RESP;
      end
      ST_TAB: begin
        ram_we    = 1'b1;
        ram_wdata = make_cell(CHAR_SPACE, fg_i, bg_i);
        cc_d      = cc_q + 1'b1;
        ph_d      = ph_inc;
        if ((ph_inc == '0) || (cc_q == CCOL_W'(COLUMNS - 1))) begin
          state_d = ST_RESP;
        end
      end
      ST_RD: begin
        state_d = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        if (is_read) begin
          rcell_d = ram_rdata;
        end else begin
          // backspace keeps the colours
          ram_we    = 1'b1;
          ram_wdata = {ram_rdata[15:8], CHAR_SPACE};
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CONSOLES; i++) begin
        cur_row_q[i] <= '0;
        cur_col_q[i] <= '0;
        cur_ph_q[i]  <= '0;
        ring_q[i]    <= '0;
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      scroll_q <= scroll_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_out && (cmd_q.kind != CMD_INVALID)) begin
        cur_row_q[con_q] <= cr_q;
        cur_col_q[con_q] <= cc_q;
        cur_ph_q[con_q]  <= ph_q;
        ring_q[con_q]    <= base_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    con_q     <= con_d;
    cr_q      <= cr_d;
    cc_q      <= cc_d;
    ph_q      <= ph_d;
    base_q    <= base_d;
    sw_q      <= sw_d;
    rowidx_q  <= rowidx_d;
    rowbase_q <= rowbase_d;
    rcell_q   <= rcell_d;
    if (load_out) begin
      out_acc_q  <= (cmd_q.kind != CMD_INVALID) && (cmd_q.kind != CMD_READ_OOR);
      out_cell_q <= is_read ? rcell_q : '0;
      out_row_q  <= (cmd_q.kind == CMD_INVALID) ? '0 : 6'(cr_q);
      out_col_q  <= (cmd_q.kind == CMD_INVALID) ? '0 : 7'(cc_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_accepted_o   = out_acc_q;
  assign out_cell_char_o  = out_cell_q[7:0];
  assign out_cell_fg_o    = out_cell_q[11:8];
  assign out_cell_bg_o    = out_cell_q[15:12];
  assign out_cursor_row_o = out_row_q;
  assign out_cursor_col_o = out_col_q;

endmodule

@@ src/text_console_character_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_character_writer
// multi-console text grid with cursor, scrolling and cell readback
// ----------------------------------------------------------------------------
// Keeps CONSOLES text consoles of ROWS x COLUMNS cells (character, foreground,
// background) in one single-port cell ram, plus a cursor and a ring base per
// console. Every request on the slave stream gives exactly one result on the
// master stream. After reset the cell ram is swept to blanks (space, colour
// 7 on 0), one cell a clock; s_axis_tready stays low until the sweep ends,
// while the apb port already works. Requests are classified on entry and
// queued two deep, so the upstream side can keep feeding while a finished
// result waits on m_axis. A sequencer then serves one request at a time over
// the cell ram's single port: a carriage return, a line feed that does not
// scroll, an invalid console or an out-of-range read goes straight to the
// result; a printable character writes one cell, a backspace or a read first
// reads one, a tab fills cells up to the next tab stop or the row end, and a
// line feed that scrolls blanks a whole row one cell per cycle; a printable
// character on a full last row scrolls first. A stalled m_axis holds the
// sequencer on its finished result. Colours for newly written cells come from
// the text_fg and text_bg registers; change them only while the block is
// idle.
// ----------------------------------------------------------------------------
module text_console_character_writer import tcw_pkg::*; #(
  parameter int unsigned CONSOLES  = CONSOLES_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // console[2:0], char_code[10:3], row[16:11],
                                           // col[23:17]
  input  logic              s_axis_tuser,  // opcode
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                           // cursor_row[21:16], cursor_col[28:22], zero pad
  output logic              m_axis_tuser   // accepted
);

  // colour registers
  logic [3:0] text_fg_q, text_bg_q;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  // front to queue, queue to back
  logic clear_done;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t front_cmd, queue_cmd;

  // result fields
  logic       res_accepted;
  logic [7:0] res_char;
  logic [3:0] res_fg, res_bg;
  logic [5:0] res_row;
  logic [6:0] res_col;

  // apb: registers are word spaced, the upper address bit selects one
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_TEXT_FG: prdata = APB_DW'(text_fg_q);
      REG_TEXT_BG: prdata = APB_DW'(text_bg_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_fg_q <= BLANK_FG;
      text_bg_q <= BLANK_BG;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_TEXT_FG) begin
        text_fg_q <= pwdata[3:0];
      end else begin
        text_bg_q <= pwdata[3:0];
      end
    end
  end

  // classify incoming requests, held off during the ram sweep
  tcw_front #(
    .CONSOLES (CONSOLES),
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS)
  ) u_front (
    .en_i        (clear_done),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .console_i   (s_axis_tdata[2:0]),
    .char_code_i (s_axis_tdata[10:3]),
    .row_i       (s_axis_tdata[16:11]),
    .col_i       (s_axis_tdata[23:17]),
    .full_i      (q_full),
    .push_o      (q_push),
    .cmd_o       (front_cmd)
  );

  // decouples classification from execution
  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (queue_cmd),
    .empty_o (q_empty)
  );

  // executes commands on the cell ram, owns the result register
  tcw_back #(
    .CONSOLES  (CONSOLES),
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fg_i             (text_fg_q),
    .bg_i             (text_bg_q),
    .empty_i          (q_empty),
    .cmd_i            (queue_cmd),
    .pop_o            (q_pop),
    .clear_done_o     (clear_done),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_accepted_o   (res_accepted),
    .out_cell_char_o  (res_char),
    .out_cell_fg_o    (res_fg),
    .out_cell_bg_o    (res_bg),
    .out_cursor_row_o (res_row),
    .out_cursor_col_o (res_col)
  );

  assign m_axis_tdata = {3'b000, res_col, res_row, res_bg, res_fg, res_char};
  assign m_axis_tuser = res_accepted;

  // no request may enter before the cell ram sweep is over
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_done |-> !(s_axis_tvalid && s_axis_tready))
    else $error("request accepted during cell ram sweep");

  // the queue is never pushed when full nor popped when empty
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("command queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("command queue underflow");

  // a pop while the sweep is running would mean the sequencer left it early
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> clear_done)
    else $error("command taken during cell ram sweep");

endmodule

@@ sim/tcw_console_monitor.sv @@
// ----------------------------------------------------------------------------
// tcw_console_monitor
// predicts and checks every result of the text console character writer
// ----------------------------------------------------------------------------
// Watches the apb port for colour writes and the request stream for accepted
// requests. It keeps its own copy of every console grid, cursor and ring base,
// and queues one expected result per request. Each result on the master
// stream is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tcw_console_monitor import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // console[2:0], char_code[10:3], row[16:11],
                                           // col[23:17]
  input  logic              s_axis_tuser,  // opcode
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [31:0]       m_axis_tdata,  // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                           // cursor_row[21:16], cursor_col[28:22], zero pad
  input  logic              m_axis_tuser,  // accepted
  output int unsigned       error_count_o,
  output int unsigned       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       accepted;
    logic [7:0] cell_char;
    logic [3:0] cell_fg;
    logic [3:0] cell_bg;
    logic [5:0] cursor_row;
    logic [6:0] cursor_col;
  } cell_reply_t;

  // shadow console state
  logic [15:0] cell_grid [CONSOLES_DEF][ROWS_DEF][COLUMNS_DEF];
  int unsigned cur_row   [CONSOLES_DEF];
  int unsigned cur_col   [CONSOLES_DEF];
  int unsigned ring_base [CONSOLES_DEF];
  logic [3:0]  fg_color;
  logic [3:0]  bg_color;

  cell_reply_t expected_replies [$];
  int unsigned errors;

  function automatic int unsigned phys_row(int unsigned con, int unsigned lrow);
    return (ring_base[con] + lrow) % ROWS_DEF;
  endfunction

  // next row, scrolling the ring and blanking the new bottom row at the end
  function automatic void advance_line(int unsigned con);
    int unsigned prow;
    cur_col[con] = 0;
    if (cur_row[con] + 1 >= ROWS_DEF) begin
      cur_row[con]   = ROWS_DEF - 1;
      ring_base[con] = (ring_base[con] + 1) % ROWS_DEF;
      prow = phys_row(con, ROWS_DEF - 1);
      for (int unsigned c = 0; c < COLUMNS_DEF; c++) begin
        cell_grid[con][prow][c] = BLANK_CELL;
      end
    end else begin
      cur_row[con]++;
    end
  endfunction

  function automatic void put_char(int unsigned con, logic [7:0] ch);
    int unsigned lrow;
    int unsigned stop;
    logic [15:0] old;
    lrow = cur_row[con];
    case (ch)
      CHAR_LF: begin
        advance_line(con);
      end
      CHAR_CR: begin
        cur_col[con] = 0;
      end
      CHAR_TAB: begin
        // fill to the next tab stop, never past the row end
        stop = (cur_col[con] / TAB_WIDTH_DEF + 1) * TAB_WIDTH_DEF;
        while (cur_col[con] < stop && cur_col[con] < COLUMNS_DEF) begin
          cell_grid[con][phys_row(con, lrow)][cur_col[con]] = {bg_color, fg_color, CHAR_SPACE};
          cur_col[con]++;
        end
      end
      CHAR_BS: begin
        // colours of the erased cell stay
        if (cur_col[con] > 0) cur_col[con]--;
        old = cell_grid[con][phys_row(con, lrow)][cur_col[con]];
        cell_grid[con][phys_row(con, lrow)][cur_col[con]] = {old[15:8], CHAR_SPACE};
      end
      default: begin
        if (cur_col[con] >= COLUMNS_DEF) advance_line(con);
        cell_grid[con][phys_row(con, cur_row[con])][cur_col[con]] = {bg_color, fg_color, ch};
        cur_col[con]++;
      end
    endcase
  endfunction

  function automatic cell_reply_t predict_cell_reply(op_e op, logic [2:0] con, logic [7:0] ch,
                                                    logic [5:0] row, logic [6:0] col);
    cell_reply_t reply;
    logic [15:0] word;
    reply = '0;
    if (con >= CONSOLES_DEF) return reply;
    if (op == OP_WRITE) begin
      put_char(con, ch);
      reply.accepted = 1'b1;
    end else if (row < ROWS_DEF && col < COLUMNS_DEF) begin
      word = cell_grid[con][phys_row(con, row)][col];
      reply.accepted  = 1'b1;
      reply.cell_char = word[7:0];
      reply.cell_fg   = word[11:8];
      reply.cell_bg   = word[15:12];
    end
    reply.cursor_row = 6'(cur_row[con]);
    reply.cursor_col = 7'(cur_col[con]);
    return reply;
  endfunction

  function automatic int unsigned field_diff(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cell_reply_t want;
    cell_reply_t got;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < CONSOLES_DEF; k++) begin
        for (int unsigned r = 0; r < ROWS_DEF; r++) begin
          for (int unsigned c = 0; c < COLUMNS_DEF; c++) begin
            cell_grid[k][r][c] = BLANK_CELL;
          end
        end
        cur_row[k]   = 0;
        cur_col[k]   = 0;
        ring_base[k] = 0;
      end
      fg_color = BLANK_FG;
      bg_color = BLANK_BG;
      expected_replies.delete();
      errors = 0;
    end else begin
      // colour registers
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_idx_e'(paddr[2]))
          REG_TEXT_FG: fg_color = pwdata[3:0];
          REG_TEXT_BG: bg_color = pwdata[3:0];
          default: ;
        endcase
      end
      // results
      if (m_axis_tvalid && m_axis_tready) begin
        got.accepted   = m_axis_tuser;
        got.cell_char  = m_axis_tdata[7:0];
        got.cell_fg    = m_axis_tdata[11:8];
        got.cell_bg    = m_axis_tdata[15:12];
        got.cursor_row = m_axis_tdata[21:16];
        got.cursor_col = m_axis_tdata[28:22];
        if (expected_replies.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_replies.pop_front();
          errors += field_diff("accepted", want.accepted, got.accepted);
          errors += field_diff("cell_char", want.cell_char, got.cell_char);
          errors += field_diff("cell_fg", want.cell_fg, got.cell_fg);
          errors += field_diff("cell_bg", want.cell_bg, got.cell_bg);
          errors += field_diff("cursor_row", want.cursor_row, got.cursor_row);
          errors += field_diff("cursor_col", want.cursor_col, got.cursor_col);
        end
      end
      // requests
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(predict_cell_reply(op_e'(s_axis_tuser), s_axis_tdata[2:0],
                                                      s_axis_tdata[10:3], s_axis_tdata[16:11],
                                                      s_axis_tdata[23:17]));
      end
    end
    error_count_o <= errors;
    outstanding_o <= expected_replies.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the text console character writer
// ----------------------------------------------------------------------------
// Drives short directed requests first, then random sequences of text lines,
// line feed bursts, control codes, reads and noise across the consoles, with
// colour register changes between phases. Both stream sides idle at random.
// The console monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REQUEST_TARGET = 850;
  localparam int unsigned IDLE_MAX       = 12;
  // a scrolling line feed blanks a whole row, so settle a bit longer than that
  localparam int unsigned SETTLE_CYCLES  = COLUMNS_DEF + 40;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [APB_DW-1:0] pwdata        = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;   // console[2:0], char_code[10:3], row[16:11],
                                           // col[23:17]
  logic              s_axis_tuser  = 1'b0; // opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;         // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                           // cursor_row[21:16], cursor_col[28:22], zero pad
  logic              m_axis_tuser;         // accepted

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned requests_sent = 0;  // requests to a valid console
  logic        steady        = 1'b0; // when set neither side idles

  text_console_character_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tcw_console_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop: the reset sweep plus all requests at their slowest fit many
  // times over in this window
  initial begin
    #20ms;
    $display("text_console_character_writer: mismatch");
    $finish;
  end

  // result side: random stall before every result, none in steady stretches
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // apb write: setup cycle, then access cycle until pready; upper data bits
  // are junk since only the low nibble is a colour
  task automatic write_register(reg_idx_e idx, logic [3:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one request; valid stays high across back-to-back requests and only
  // drops for a gap
  task automatic send_request(op_e op, logic [2:0] con, logic [7:0] ch,
                              logic [5:0] row, logic [6:0] col);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {col, row, ch, con};
    do @(posedge clk_i); while (!s_axis_tready);
    if (con < CONSOLES_DEF) requests_sent++;
  endtask

  // unused fields of a request carry random junk
  task automatic write_char(logic [2:0] con, logic [7:0] ch);
    send_request(OP_WRITE, con, ch, 6'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(logic [2:0] con, logic [5:0] row, logic [6:0] col);
    send_request(OP_READ, con, 8'($urandom), row, col);
  endtask

  // lower valid and wait until every expected result has come back; the
  // first check waits for the next edge so the last request is already counted
  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // any byte that is not one of the four control codes
  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == CHAR_LF || b == CHAR_CR || b == CHAR_TAB || b == CHAR_BS);
    return b;
  endfunction

  // read column, mostly in range, sometimes past the row end
  function automatic logic [6:0] read_column();
    if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, COLUMNS_DEF - 1));
    return 7'($urandom_range(COLUMNS_DEF, 127));
  endfunction

  function automatic logic [7:0] control_byte();
    case ($urandom_range(0, 4))
      0:       return CHAR_LF;
      1:       return CHAR_CR;
      2:       return CHAR_TAB;
      3:       return CHAR_BS;
      default: return printable_byte();
    endcase
  endfunction

  // one random sequence, on one console but for noise; console 0 gets the
  // largest share, to fill rows, wrap and scroll the ring several times
  task automatic run_sequence();
    int unsigned pick;
    int unsigned count;
    logic [2:0]  con;
    steady = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 45)      con = 3'd0;
    else if (pick < 70) con = 3'd1;
    else if (pick < 92) con = 3'($urandom_range(2, CONSOLES_DEF - 1));
    else                con = 3'($urandom_range(CONSOLES_DEF, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // a line of text, long enough at times to wrap, then an ending or none
        count = $urandom_range(1, 90);
        repeat (count) write_char(con, printable_byte());
        case ($urandom_range(0, 4))
          0: write_char(con, CHAR_LF);
          1: begin
            write_char(con, CHAR_CR);
            write_char(con, CHAR_LF);
          end
          2: write_char(con, CHAR_TAB);
          3: write_char(con, CHAR_BS);
          default: ;
        endcase
      end
      4, 5: begin
        // line feed burst, long enough at times to reach the bottom row and scroll
        count = $urandom_range(20, 70);
        repeat (count) write_char(con, CHAR_LF);
      end
      6: begin
        count = $urandom_range(1, 12);
        repeat (count) write_char(con, control_byte());
      end
      7, 8: begin
        count = $urandom_range(1, 8);
        repeat (count) read_cell(con, 6'($urandom), read_column());
      end
      default: begin
        // noise: anything the fields allow
        count = $urandom_range(1, 6);
        repeat (count) begin
          send_request(op_e'($urandom_range(0, 1)), 3'($urandom), 8'($urandom),
                       6'($urandom), 7'($urandom));
        end
      end
    endcase
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // colours at their top value
    write_register(REG_TEXT_FG, 4'hf);
    write_register(REG_TEXT_BG, 4'hf);

    // directed: every control code, byte extremes, edge positions, bad consoles
    write_char(3'd0, 8'h41);
    write_char(3'd0, 8'h00);
    write_char(3'd0, 8'hff);
    write_char(3'd0, CHAR_TAB);                    // pad to the first tab stop
    read_cell(3'd0, 6'd0, 7'd0);
    read_cell(3'd0, 6'd0, 7'd5);                   // cell filled by the tab
    write_char(3'd0, CHAR_BS);
    write_char(3'd0, CHAR_CR);
    write_char(3'd0, CHAR_BS);                     // backspace already at column 0
    read_cell(3'd0, 6'd0, 7'd0);
    write_char(3'd0, CHAR_LF);
    write_char(3'(CONSOLES_DEF - 1), 8'h7a);
    read_cell(3'(CONSOLES_DEF - 1), 6'd63, 7'(COLUMNS_DEF - 1));
    read_cell(3'(CONSOLES_DEF - 1), 6'd0, 7'(COLUMNS_DEF));   // column past the end
    read_cell(3'd0, 6'd0, 7'h7f);
    write_char(3'd7, 8'h78);                       // console out of range
    read_cell(3'd7, 6'd0, 7'd0);
    read_cell(3'd3, 6'd0, 7'd0);                   // untouched console, reset blank

    // colours at their bottom value
    wait_for_replies();
    write_register(REG_TEXT_FG, 4'h0);
    write_register(REG_TEXT_BG, 4'h0);
    write_char(3'd1, 8'h7e);
    read_cell(3'd1, 6'd0, 7'd0);

    // random phases, new colours in between while the block is idle
    for (int unsigned phase = 0; phase < 4; phase++) begin
      wait_for_replies();
      write_register(REG_TEXT_FG, 4'($urandom));
      write_register(REG_TEXT_BG, 4'($urandom));
      while (requests_sent < REQUEST_TARGET * (phase + 1) / 4) run_sequence();
    end

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && outstanding == 0) begin
      $display("text_console_character_writer: match");
    end else begin
      $display("text_console_character_writer: mismatch");
    end
    $finish;
  end

endmodule
